/* sv/i64alu_pkg.sv */
`default_nettype none

package i64alu_pkg;

    localparam int DATA_W = 64;
    // shared unit width: one spare bit for the division trial subtract
    localparam int UNIT_W = DATA_W + 1;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REM = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADOP   = 2'd2;
    localparam logic [STAT_W-1:0] ST_SKIPPED = 2'd3;

    typedef struct packed {
        logic [UNIT_W-1:0] x;
        logic [UNIT_W-1:0] y;
        logic              sub;
    } unit_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] sum;
        logic              cout;
    } unit_rsp_t;

endpackage

`default_nettype wire

/* sv/i64alu_addsub.sv */
`default_nettype none

// Shared add/subtract unit; on subtract, cout high means x >= y.
module i64alu_addsub (
    input  wire i64alu_pkg::unit_req_t req,
    output i64alu_pkg::unit_rsp_t      rsp
);

    logic [i64alu_pkg::UNIT_W-1:0] y_eff;
    logic [i64alu_pkg::UNIT_W:0]   total;

    assign y_eff = req.sub ? ~req.y : req.y;
    assign total = {1'b0, req.x} + {1'b0, y_eff}
                 + {{i64alu_pkg::UNIT_W{1'b0}}, req.sub};

    assign rsp.sum  = total[i64alu_pkg::UNIT_W-1:0];
    assign rsp.cout = total[i64alu_pkg::UNIT_W];

endmodule

`default_nettype wire

/* sv/int64_batch_alu_with_divide.sv */
`default_nettype none

// Add/subtract runs through S_ADDSUB, multiply through S_MUL, divide and remainder
// through S_ABSA, S_ABSB, S_DIV and S_FIXUP, then each through S_FIN; skipped and
// failed elements go straight to S_FIN. One element at a time; divide sets the worst
// case, paced by the 64 radix-2 passes through the single shared add/subtract unit.
// Reset (aresetn, synchronous, active low) clears the sequencer, the output
// valid and the batch error flag; datapath registers are left as they are.
module int64_batch_alu_with_divide (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // input channel
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  [i64alu_pkg::KIND_W-1:0]          s_kind,
    input  wire  signed [i64alu_pkg::DATA_W-1:0]   s_operand_a,
    input  wire  signed [i64alu_pkg::DATA_W-1:0]   s_operand_b,
    input  wire                                    s_last_in_batch,
    // result channel
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic signed [i64alu_pkg::DATA_W-1:0]   m_value,
    output logic [i64alu_pkg::STAT_W-1:0]          m_status,
    output logic                                   m_end_of_batch
);

    localparam int DW    = i64alu_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW);

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADDSUB = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_ABSA   = 3'd3;
    localparam logic [2:0] S_ABSB   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FIXUP  = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    logic [2:0]                      state_reg, state_next;
    logic [i64alu_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic                            last_reg, last_next;
    logic [DW-1:0]                   a_reg, a_next;
    logic [DW-1:0]                   b_reg, b_next;
    logic [DW-1:0]                   acc_reg, acc_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            neg_reg, neg_next;
    logic [i64alu_pkg::STAT_W-1:0]   status_reg, status_next;
    logic                            failed_reg, failed_next;
    logic                            m_valid_reg, m_valid_next;
    logic [DW-1:0]                   m_value_reg, m_value_next;
    logic [i64alu_pkg::STAT_W-1:0]   m_status_reg, m_status_next;
    logic                            m_eob_reg, m_eob_next;

    i64alu_pkg::unit_req_t req;
    i64alu_pkg::unit_rsp_t rsp;

    logic                            fail_set;
    logic [DW:0]                     shifted;
    logic [DW-1:0]                   fix_src;

    i64alu_addsub u_addsub (
        .req (req),
        .rsp (rsp)
    );

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_end_of_batch = m_eob_reg;

    // partial remainder shifted left with the next dividend bit
    assign shifted = {acc_reg, a_reg[DW-1]};
    assign fix_src = (kind_reg == i64alu_pkg::KIND_DIV) ? a_reg : acc_reg;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        last_next     = last_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        status_next   = status_reg;
        failed_next   = failed_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_eob_next    = m_eob_reg;
        fail_set      = 1'b0;
        req.x         = '0;
        req.y         = '0;
        req.sub       = 1'b0;

        // the consumer took the pending result
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next   = s_kind;
                    last_next   = s_last_in_batch;
                    a_next      = s_operand_a;
                    b_next      = s_operand_b;
                    acc_next    = '0;
                    cnt_next    = '0;
                    status_next = i64alu_pkg::ST_OK;
                    if (failed_reg) begin
                        // batch already stopped: skip without touching the unit
                        status_next = i64alu_pkg::ST_SKIPPED;
                        state_next  = S_FIN;
                    end else begin
                        case (s_kind)
                            i64alu_pkg::KIND_ADD,
                            i64alu_pkg::KIND_SUB: begin
                                state_next = S_ADDSUB;
                            end
                            i64alu_pkg::KIND_MUL: begin
                                state_next = S_MUL;
                            end
                            i64alu_pkg::KIND_DIV,
                            i64alu_pkg::KIND_REM: begin
                                if (s_operand_b == '0) begin
                                    status_next = i64alu_pkg::ST_DIVZERO;
                                    fail_set    = 1'b1;
                                    state_next  = S_FIN;
                                end else begin
                                    // quotient sign from both, remainder from dividend
                                    neg_next   = (s_kind == i64alu_pkg::KIND_DIV)
                                               ? (s_operand_a[DW-1] ^ s_operand_b[DW-1])
                                               : s_operand_a[DW-1];
                                    state_next = S_ABSA;
                                end
                            end
                            default: begin
                                status_next = i64alu_pkg::ST_BADOP;
                                fail_set    = 1'b1;
                                state_next  = S_FIN;
                            end
                        endcase
                    end
                    // end of batch clears the error, even on a failed element
                    failed_next = s_last_in_batch ? 1'b0 : (failed_reg | fail_set);
                end
            end

            S_ADDSUB: begin
                req.x      = {1'b0, a_reg};
                req.y      = {1'b0, b_reg};
                req.sub    = (kind_reg == i64alu_pkg::KIND_SUB);
                acc_next   = rsp.sum[DW-1:0];
                state_next = S_FIN;
            end

            S_MUL: begin
                // shift-and-add, low half of the product only
                req.x  = {1'b0, acc_reg};
                req.y  = {1'b0, a_reg};
                if (b_reg[0]) begin
                    acc_next = rsp.sum[DW-1:0];
                end
                a_next   = {a_reg[DW-2:0], 1'b0};
                b_next   = {1'b0, b_reg[DW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_FIN;
                end
            end

            S_ABSA: begin
                req.y   = {1'b0, a_reg};
                req.sub = 1'b1;
                if (a_reg[DW-1]) begin
                    a_next = rsp.sum[DW-1:0];
                end
                state_next = S_ABSB;
            end

            S_ABSB: begin
                req.y   = {1'b0, b_reg};
                req.sub = 1'b1;
                if (b_reg[DW-1]) begin
                    b_next = rsp.sum[DW-1:0];
                end
                state_next = S_DIV;
            end

            S_DIV: begin
                // restoring step: trial subtract, keep it when no borrow
                req.x   = shifted;
                req.y   = {1'b0, b_reg};
                req.sub = 1'b1;
                if (rsp.cout) begin
                    acc_next = rsp.sum[DW-1:0];
                end else begin
                    acc_next = shifted[DW-1:0];
                end
                a_next   = {a_reg[DW-2:0], rsp.cout};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_FIXUP;
                end
            end

            S_FIXUP: begin
                req.y   = {1'b0, fix_src};
                req.sub = 1'b1;
                acc_next   = neg_reg ? rsp.sum[DW-1:0] : fix_src;
                state_next = S_FIN;
            end

            S_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = (status_reg == i64alu_pkg::ST_OK) ? acc_reg : '0;
                    m_status_next = status_reg;
                    m_eob_next    = last_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        status_reg   <= status_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_eob_reg    <= m_eob_next;
    end

endmodule

`default_nettype wire
